### src/gap_pkg.sv
`default_nettype none
package gap_pkg;

  localparam int DEF_SAMPLE_BITS = 16;

  localparam int AREA_W     = 13;
  localparam int CHANS_W    = 11;
  localparam int IMAGES_W   = 9;
  localparam int CHAN_IDX_W = 10;
  localparam int IMG_CNT_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int MAX_AREA     = 4096;
  localparam int MAX_CHANNELS = 1024;
  localparam int MAX_IMAGES   = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AREA     = 2'd0,
    CFG_CHANNELS = 2'd1,
    CFG_IMAGES   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_ctrl_t;

endpackage
`default_nettype wire

### src/gap_if.sv
`default_nettype none
interface gap_in_if #(parameter int SAMPLE_BITS = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface gap_out_if import gap_pkg::*; #(parameter int SAMPLE_BITS = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic [CHAN_IDX_W-1:0]         channel_index;
  logic                          batch_done;
  modport source (output valid, output mean, output channel_index, output batch_done,
                  input ready);
  modport sink   (input valid, input mean, input channel_index, input batch_done,
                  output ready);
endinterface

interface gap_cfg_if import gap_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/gap_front.sv
`default_nettype none
module gap_front import gap_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_sample,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]              cfg_index,
  input  wire logic [CFG_DATA_W-1:0]             cfg_data,
  input  wire logic                              q_full,
  output q_ctrl_t                                q_ctrl,
  output logic [SAMPLE_BITS+AREA_W-1:0]          push_sum,
  output logic [AREA_W-1:0]                      push_area,
  output logic [CHAN_IDX_W-1:0]                  push_chan,
  output logic                                   push_done
);

  localparam int SW = SAMPLE_BITS + AREA_W;

  logic [AREA_W-1:0]     area_r;
  logic [CHANS_W-1:0]    chans_r;
  logic [IMAGES_W-1:0]   images_r;
  logic [SW-1:0]         sum_r;
  logic [AREA_W-1:0]     scnt_r;
  logic [CHAN_IDX_W-1:0] ccnt_r;
  logic [IMG_CNT_W-1:0]  icnt_r;

  logic [AREA_W-1:0]     a_eff;
  logic [CHANS_W-1:0]    c_eff;
  logic [IMAGES_W-1:0]   n_eff;
  logic [SW-1:0]         sum_nxt;
  logic                  smp_last;
  logic                  chan_last;
  logic                  img_last;
  logic                  accept;
  logic                  cfg_hit;

  always_comb begin
    if (area_r == '0) begin
      a_eff = AREA_W'(1);
    end else if (area_r > AREA_W'(MAX_AREA)) begin
      a_eff = AREA_W'(MAX_AREA);
    end else begin
      a_eff = area_r;
    end
    if (chans_r == '0) begin
      c_eff = CHANS_W'(1);
    end else if (chans_r > CHANS_W'(MAX_CHANNELS)) begin
      c_eff = CHANS_W'(MAX_CHANNELS);
    end else begin
      c_eff = chans_r;
    end
    if (images_r == '0) begin
      n_eff = IMAGES_W'(1);
    end else if (images_r > IMAGES_W'(MAX_IMAGES)) begin
      n_eff = IMAGES_W'(MAX_IMAGES);
    end else begin
      n_eff = images_r;
    end
  end

  assign sum_nxt   = sum_r + {{AREA_W{in_sample[SAMPLE_BITS-1]}}, in_sample};
  assign smp_last  = ({1'b0, scnt_r} + (AREA_W+1)'(1)) >= {1'b0, a_eff};
  assign chan_last = ({{(CHANS_W-CHAN_IDX_W){1'b0}}, ccnt_r} + CHANS_W'(1)) >= c_eff;
  assign img_last  = ({1'b0, icnt_r} + IMAGES_W'(1)) >= n_eff;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign cfg_hit   = cfg_valid && (cfg_index == CFG_AREA || cfg_index == CFG_CHANNELS ||
                                   cfg_index == CFG_IMAGES);

  assign q_ctrl.push = accept && smp_last;
  assign q_ctrl.full = q_full;
  assign push_sum    = sum_nxt;
  assign push_area   = a_eff;
  assign push_chan   = ccnt_r;
  assign push_done   = chan_last && img_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r   <= AREA_W'(1);
      chans_r  <= CHANS_W'(1);
      images_r <= IMAGES_W'(1);
      sum_r    <= '0;
      scnt_r   <= '0;
      ccnt_r   <= '0;
      icnt_r   <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        CFG_AREA:     area_r   <= cfg_data;
        CFG_CHANNELS: chans_r  <= cfg_data[CHANS_W-1:0];
        CFG_IMAGES:   images_r <= cfg_data[IMAGES_W-1:0];
        default:      area_r   <= area_r;
      endcase
      sum_r  <= '0;
      scnt_r <= '0;
      ccnt_r <= '0;
      icnt_r <= '0;
    end else if (accept) begin
      if (smp_last) begin
        sum_r  <= '0;
        scnt_r <= '0;
        if (chan_last) begin
          ccnt_r <= '0;
          icnt_r <= img_last ? '0 : icnt_r + IMG_CNT_W'(1);
        end else begin
          ccnt_r <= ccnt_r + CHAN_IDX_W'(1);
        end
      end else begin
        sum_r  <= sum_nxt;
        scnt_r <= scnt_r + AREA_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

### src/gap_queue.sv
`default_nettype none
module gap_queue #(
  parameter int W = 53
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic              full,
  output logic              not_empty,
  output logic [W-1:0]      head_data
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### src/gap_back.sv
`default_nettype none
module gap_back import gap_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  output logic                               q_pop,
  input  wire logic [SAMPLE_BITS+AREA_W-1:0] q_sum,
  input  wire logic [AREA_W-1:0]             q_area,
  input  wire logic [CHAN_IDX_W-1:0]         q_chan,
  input  wire logic                          q_done,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_mean,
  output logic [CHAN_IDX_W-1:0]              out_chan,
  output logic                               out_done
);

  localparam int SW     = SAMPLE_BITS + AREA_W;
  localparam int STEP_W = $clog2(SW);

  bk_state_t state_r, state_nxt;

  logic [SW-1:0]          quo_r;
  logic [AREA_W-1:0]      rem_r;
  logic [AREA_W-1:0]      div_r;
  logic                   neg_r;
  logic [STEP_W-1:0]      step_r;
  logic [SAMPLE_BITS-1:0] mean_r;
  logic [CHAN_IDX_W-1:0]  chan_r;
  logic                   done_r;

  logic [AREA_W:0]        rem_sh;
  logic                   ge;
  logic [AREA_W:0]        diff;
  logic [SW-1:0]          quo_nxt;
  logic [AREA_W-1:0]      rem_nxt;
  logic [SAMPLE_BITS-1:0] q_mag;
  logic [SW-1:0]          sum_abs;
  logic                   load;
  logic                   last_step;

  assign rem_sh    = {rem_r, quo_r[SW-1]};
  assign ge        = rem_sh >= {1'b0, div_r};
  assign diff      = rem_sh - {1'b0, div_r};
  assign rem_nxt   = ge ? diff[AREA_W-1:0] : rem_sh[AREA_W-1:0];
  assign quo_nxt   = {quo_r[SW-2:0], ge};
  assign q_mag     = quo_nxt[SAMPLE_BITS-1:0];
  assign sum_abs   = q_sum[SW-1] ? ('0 - q_sum) : q_sum;
  assign last_step = step_r == STEP_W'(SW-1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_DIV;
      BK_DIV:  if (last_step) state_nxt = BK_OUT;
      BK_OUT:  if (out_ready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    load      = (state_r == BK_IDLE) && q_valid;
    q_pop     = load;
    out_valid = state_r == BK_OUT;
  end

  assign out_mean = $signed(mean_r);
  assign out_chan = chan_r;
  assign out_done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo_r  <= sum_abs;
      rem_r  <= '0;
      div_r  <= q_area;
      neg_r  <= q_sum[SW-1];
      step_r <= '0;
      chan_r <= q_chan;
      done_r <= q_done;
    end else if (state_r == BK_DIV) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r + STEP_W'(1);
      if (last_step) begin
        mean_r <= neg_r ? ('0 - q_mag) : q_mag;
      end
    end
  end

endmodule
`default_nettype wire

### src/global_average_pool.sv
// global average pooling over a stream of signed q8.8 samples
// in_chan: one sample per transfer, channel by channel, image by image;
//   each channel's area samples arrive back to back
// out_chan: one transfer per channel with the truncated mean, the channel
//   index and batch_done on the last channel of the last image
// cfg_chan: index 0 area, 1 channels, 2 images; cfg_ready is always high,
//   a write to a known index restarts the stream at sample 0
// throughput: the front takes one sample per cycle while the two-entry
//   result queue has room; the back loads one mean at a time from the queue,
//   divides it in the bit-serial divider and holds it until out_ready
// path: the last sample's sum is pushed into the queue and taken by the back
//   once the divider is free
// reset: registers return to 1, all counters and the queue clear
// when the receiver stalls the mean holds on out_chan, the queue fills
//   behind it and in_ready drops only once both queue entries are taken
`default_nettype none
module global_average_pool import gap_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gap_in_if.sink     in_chan,
  gap_out_if.source  out_chan,
  gap_cfg_if.sink    cfg_chan
);

  localparam int SW  = SAMPLE_BITS + AREA_W;
  localparam int Q_W = SW + AREA_W + CHAN_IDX_W + 1;

  q_ctrl_t               q_ctrl;
  logic                  in_ready;
  logic                  cfg_ready;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic [Q_W-1:0]        q_head;
  logic [SW-1:0]         push_sum;
  logic [AREA_W-1:0]     push_area;
  logic [CHAN_IDX_W-1:0] push_chan;
  logic                  push_done;

  assign in_chan.ready  = in_ready;
  assign cfg_chan.ready = cfg_ready;

  gap_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .in_sample (in_chan.sample),
    .cfg_valid (cfg_chan.valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_chan.index),
    .cfg_data  (cfg_chan.data),
    .q_full    (q_full),
    .q_ctrl    (q_ctrl),
    .push_sum  (push_sum),
    .push_area (push_area),
    .push_chan (push_chan),
    .push_done (push_done)
  );

  gap_queue #(.W(Q_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_ctrl.push),
    .push_data ({push_sum, push_area, push_chan, push_done}),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head_data (q_head)
  );

  gap_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_sum     (q_head[Q_W-1 -: SW]),
    .q_area    (q_head[AREA_W+CHAN_IDX_W -: AREA_W]),
    .q_chan    (q_head[CHAN_IDX_W:1]),
    .q_done    (q_head[0]),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_mean  (out_chan.mean),
    .out_chan  (out_chan.channel_index),
    .out_done  (out_chan.batch_done)
  );

endmodule
`default_nettype wire

### src/gap_checker.sv
`default_nettype none
module gap_checker import gap_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [SAMPLE_BITS-1:0] out_mean,
  input wire logic [CHAN_IDX_W-1:0]  out_chan,
  input wire logic                   out_done,
  input wire logic                   cfg_valid,
  input wire logic                   cfg_ready
);

  ast_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean) && $stable(out_chan) &&
    $stable(out_done))
    else $error("result changed while stalled");

  ast_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  ast_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  ast_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind global_average_pool gap_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_gap_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_mean  (out_chan.mean),
  .out_chan  (out_chan.channel_index),
  .out_done  (out_chan.batch_done),
  .cfg_valid (cfg_chan.valid),
  .cfg_ready (cfg_chan.ready)
);
`default_nettype wire

### tb/sv/gap_pool_checker.sv
module gap_pool_checker import gap_pkg::*; #(
  parameter int SB = DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic signed [SB-1:0]   in_sample,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic signed [SB-1:0]   out_mean,
  input  logic [CHAN_IDX_W-1:0]  out_channel,
  input  logic                   out_done,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     pending,
  output int                     errors
);

  typedef struct packed {
    logic signed [SB-1:0]  mean;
    logic [CHAN_IDX_W-1:0] chan;
    logic                  done;
  } pool_mean_t;

  pool_mean_t means_q[$];

  logic [AREA_W-1:0]   area_r = 1;
  logic [CHANS_W-1:0]  chans_r = 1;
  logic [IMAGES_W-1:0] imgs_r = 1;
  longint              sum_acc = 0;
  int                  samp_cnt = 0;
  int                  chan_cnt = 0;
  int                  img_cnt = 0;
  int                  n_pend = 0;
  int                  err_count = 0;

  assign pending = n_pend;
  assign errors  = err_count;

  function automatic int effective(input int v, input int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic flag(input string what);
    err_count++;
    if (err_count <= 10) $display("[%0t] gap check: %s", $time, what);
  endtask

  always @(posedge clk) begin
    pool_mean_t got;
    pool_mean_t want;
    longint     q;
    int         a;
    int         c;
    int         n;
    bit         known;
    if (!rst_n) begin
      area_r   = 1;
      chans_r  = 1;
      imgs_r   = 1;
      sum_acc  = 0;
      samp_cnt = 0;
      chan_cnt = 0;
      img_cnt  = 0;
      means_q.delete();
    end else begin
      // result transfer, compared against the oldest predicted mean
      if (out_valid && out_ready) begin
        got.mean = out_mean;
        got.chan = out_channel;
        got.done = out_done;
        if (means_q.size() == 0) begin
          flag($sformatf("unexpected mean %0d channel %0d done %0b",
                         $signed(got.mean), got.chan, got.done));
        end else begin
          want = means_q.pop_front();
          if (got.mean !== want.mean || got.chan !== want.chan || got.done !== want.done) begin
            flag($sformatf("expected mean %0d channel %0d done %0b, actual mean %0d channel %0d done %0b",
                           $signed(want.mean), want.chan, want.done,
                           $signed(got.mean), got.chan, got.done));
          end
        end
      end

      // register write, a known index restarts the stream
      if (cfg_valid && cfg_ready) begin
        known = 1'b1;
        case (cfg_index)
          CFG_AREA:     area_r  = cfg_data[AREA_W-1:0];
          CFG_CHANNELS: chans_r = cfg_data[CHANS_W-1:0];
          CFG_IMAGES:   imgs_r  = cfg_data[IMAGES_W-1:0];
          default:      known = 1'b0;
        endcase
        if (known) begin
          sum_acc  = 0;
          samp_cnt = 0;
          chan_cnt = 0;
          img_cnt  = 0;
        end
      end

      // sample transfer
      if (in_valid && in_ready) begin
        a = effective(area_r, MAX_AREA);
        c = effective(chans_r, MAX_CHANNELS);
        n = effective(imgs_r, MAX_IMAGES);
        sum_acc += longint'(in_sample);
        samp_cnt++;
        if (samp_cnt >= a) begin
          q = sum_acc / a;
          want.mean = q[SB-1:0];
          want.chan = chan_cnt[CHAN_IDX_W-1:0];
          want.done = (chan_cnt + 1 >= c) && (img_cnt + 1 >= n);
          means_q.push_back(want);
          sum_acc  = 0;
          samp_cnt = 0;
          if (chan_cnt + 1 >= c) begin
            chan_cnt = 0;
            if (img_cnt + 1 >= n) img_cnt = 0;
            else img_cnt++;
          end else begin
            chan_cnt++;
          end
        end
      end
    end
    n_pend = means_q.size();
  end

endmodule

### tb/sv/tb_global_average_pool.sv
module tb_global_average_pool;
  import gap_pkg::*;

  localparam int SB            = DEF_SAMPLE_BITS;
  localparam int SETTLE_CYCLES = SB + 30;
  localparam int RANDOM_ITEMS  = 1400;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam logic [SB-1:0] MAX_S = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] MIN_S = {1'b1, {(SB-1){1'b0}}};

  logic clk = 1'b0;
  logic rst_n;
  bit   no_gaps = 1'b0;
  int   pending;
  int   errors;
  int   rand_sent = 0;

  always #5 clk = ~clk;

  gap_in_if #(.SAMPLE_BITS(SB))  in_if ();
  gap_out_if #(.SAMPLE_BITS(SB)) out_if ();
  gap_cfg_if                     cfg_if ();

  global_average_pool #(.SAMPLE_BITS(SB)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  gap_pool_checker #(.SB(SB)) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_ready    (in_if.ready),
    .in_sample   (in_if.sample),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_mean    (out_if.mean),
    .out_channel (out_if.channel_index),
    .out_done    (out_if.batch_done),
    .cfg_valid   (cfg_if.valid),
    .cfg_ready   (cfg_if.ready),
    .cfg_index   (cfg_if.index),
    .cfg_data    (cfg_if.data),
    .pending     (pending),
    .errors      (errors)
  );

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [SB-1:0] pick_sample();
    int            r;
    logic [SB-1:0] v;
    r = $urandom_range(0, 9);
    v = SB'($urandom);
    if (r < 6) return v;
    if (r < 8) return r[0] ? MAX_S : MIN_S;
    v = SB'($urandom_range(0, 16));
    return v - SB'(8);
  endfunction

  task automatic send_sample(input logic [SB-1:0] s);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    do @(negedge clk); while (!in_if.ready);
    @(posedge clk);
  endtask

  task automatic send_run(input int count, input logic [SB-1:0] s);
    repeat (count) send_sample(s);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sample(pick_sample());
  endtask

  // hold the sender until every predicted mean has been taken
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(negedge clk); while (!cfg_if.ready);
    @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_shape(input logic [CFG_DATA_W-1:0] a, input logic [CFG_DATA_W-1:0] c,
                           input logic [CFG_DATA_W-1:0] n);
    write_reg(CFG_AREA, a);
    write_reg(CFG_CHANNELS, c);
    write_reg(CFG_IMAGES, n);
  endtask

  // receiver stalls
  initial begin
    int g;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        out_if.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin
    int r;
    int a;
    int c;
    int n;
    int batch;
    int len;
    int mid;
    bit mid_write;
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_AREA;
    cfg_if.data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset shape: every sample is a whole batch
    send_sample(MAX_S);
    send_sample(MIN_S);
    send_sample('0);
    send_sample('1);
    send_sample(SB'(1));

    // 4 samples, 3 channels, 2 images, then wrap into a new batch
    set_shape(4, 3, 2);
    send_run(4, MIN_S);
    send_run(4, MAX_S);
    send_run(3, '1);
    send_sample('0);
    send_sample(SB'(-5));
    send_run(3, '0);
    drain();
    send_random(12);

    // write in the middle of a channel drops the partial sum
    send_random(2);
    write_reg(CFG_AREA, 3);
    send_random(3);

    // zero registers act as one
    set_shape(0, 0, 0);
    send_random(3);

    // unmapped index leaves the partial sum alone
    write_reg(CFG_AREA, 2);
    send_sample(SB'(100));
    write_reg(CFG_UNMAPPED, '1);
    send_sample(SB'(-31));

    // oversized image count
    set_shape(1, 1, '1);
    send_random(MAX_IMAGES + 4);

    while (rand_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      a = (r < 5) ? 0 : (r < 75) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      r = $urandom_range(0, 99);
      c = (r < 5) ? 0 : (r < 80) ? $urandom_range(1, 4) : $urandom_range(5, 2047);
      r = $urandom_range(0, 99);
      n = (r < 5) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(5, 511);
      set_shape(CFG_DATA_W'(a), CFG_DATA_W'(c), CFG_DATA_W'(n));
      no_gaps = ($urandom_range(0, 3) == 0);

      batch = (a == 0 ? 1 : a) * (c == 0 ? 1 : c) * (n == 0 ? 1 : n);
      len = (batch <= 300) ? batch * $urandom_range(1, 2) : $urandom_range(20, 150);
      // sometimes leave a channel unfinished before the next write
      if ($urandom_range(0, 9) == 0) len += $urandom_range(1, a == 0 ? 1 : a);
      mid = $urandom_range(0, len - 1);
      mid_write = ($urandom_range(0, 7) == 0);

      for (int i = 0; i < len; i++) begin
        if (mid_write && i == mid) write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 149) == 0) drain();
        send_sample(pick_sample());
        rand_sent++;
      end
    end

    no_gaps = 1'b0;
    drain();
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #15000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
